// ===== hw/rtl/esr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esr_pkg: shared types and codes of the exact symbolic rational ALU
// Operation codes of the shared arithmetic unit, its control and status
// groups, and the action and status codes seen on the top-level ports.
// ----------------------------------------------------------------------------
package esr_pkg;

  // Operations of the shared iterative unit.
  typedef enum logic [2:0] {
    UOP_MUL,   // shift-add multiply, one multiplier bit per cycle
    UOP_DIV,   // restoring divide over the full word
    UOP_DIVS,  // restoring divide over the short (radicand) word
    UOP_GCD,   // binary GCD, one subtract, swap or shift per cycle
    UOP_ABS,   // absolute difference with an order flag
    UOP_ADD    // add, done raised in the cycle after the start
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_ctrl_t;

  typedef struct packed {
    logic done;
    logic lt;
  } unit_stat_t;

  // Actions on the command port.
  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FORM = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

endpackage
`default_nettype wire

// ===== hw/rtl/esr_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esr_unit: shared iterative arithmetic unit
// Wide adders and subtractors serve multiply, divide, GCD, absolute
// difference and add. Results are valid in the cycle that done is high.
// ----------------------------------------------------------------------------
module esr_unit #(
  parameter int WIDTH = 80,
  parameter int SHORT = 32
) (
  input  wire                      clk,
  input  wire                      rst,
  input  esr_pkg::unit_ctrl_t      ctrl,
  input  wire        [WIDTH-1:0]   a,
  input  wire        [WIDTH-1:0]   b,
  output esr_pkg::unit_stat_t      stat,
  output logic       [WIDTH-1:0]   res,
  output logic       [WIDTH-1:0]   rmd
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  typedef enum logic [2:0] {U_IDLE, U_MUL, U_DIV, U_GCD, U_GSH, U_ABS} ustate_t;

  ustate_t          st;
  logic             done;
  logic             lt;
  logic [WIDTH:0]   acc;
  logic [WIDTH-1:0] x;
  logic [WIDTH-1:0] y;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] kk;

  logic [WIDTH:0]   shv;
  logic [WIDTH:0]   shsub;
  logic [WIDTH:0]   diff;

  // Shifted partial remainder and its trial subtraction.
  assign shv   = {acc[WIDTH-1:0], x[WIDTH-1]};
  assign shsub = shv - {1'b0, y};
  // Shared compare-subtract for GCD and absolute difference.
  assign diff  = {1'b0, x} - {1'b0, y};

  assign stat.done = done;
  assign stat.lt   = lt;
  assign res       = x;
  assign rmd       = acc[WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= U_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        U_IDLE: begin
          if (ctrl.start) begin
            case (ctrl.op)
              esr_pkg::UOP_MUL: begin
                acc <= '0;
                x   <= a;
                y   <= b;
                st  <= U_MUL;
              end
              esr_pkg::UOP_DIV: begin
                acc <= '0;
                x   <= a;
                y   <= b;
                cnt <= CNT_W'(WIDTH);
                st  <= U_DIV;
              end
              esr_pkg::UOP_DIVS: begin
                acc <= '0;
                x   <= a << (WIDTH - SHORT);
                y   <= b;
                cnt <= CNT_W'(SHORT);
                st  <= U_DIV;
              end
              esr_pkg::UOP_GCD: begin
                x  <= a;
                y  <= b;
                kk <= '0;
                st <= U_GCD;
              end
              esr_pkg::UOP_ABS: begin
                x  <= a;
                y  <= b;
                lt <= 1'b0;
                st <= U_ABS;
              end
              esr_pkg::UOP_ADD: begin
                x    <= a + b;
                done <= 1'b1;
              end
              default: st <= U_IDLE;
            endcase
          end
        end
        U_MUL: begin
          if (y == '0) begin
            x    <= acc[WIDTH-1:0];
            done <= 1'b1;
            st   <= U_IDLE;
          end else begin
            if (y[0]) begin
              acc <= acc + {1'b0, x};
            end
            x <= x << 1;
            y <= y >> 1;
          end
        end
        U_DIV: begin
          if (cnt == '0) begin
            done <= 1'b1;
            st   <= U_IDLE;
          end else begin
            if (!shsub[WIDTH]) begin
              acc <= shsub;
              x   <= {x[WIDTH-2:0], 1'b1};
            end else begin
              acc <= shv;
              x   <= {x[WIDTH-2:0], 1'b0};
            end
            cnt <= cnt - 1'b1;
          end
        end
        U_GCD: begin
          if (x == '0) begin
            x  <= y;
            st <= U_GSH;
          end else if (y == '0) begin
            st <= U_GSH;
          end else if (!x[0] && !y[0]) begin
            x  <= x >> 1;
            y  <= y >> 1;
            kk <= kk + 1'b1;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (diff[WIDTH]) begin
            // Keep the larger value in x so one subtractor serves.
            x <= y;
            y <= x;
          end else begin
            x <= diff[WIDTH-1:0];
          end
        end
        U_GSH: begin
          if (kk == '0) begin
            done <= 1'b1;
            st   <= U_IDLE;
          end else begin
            x  <= x << 1;
            kk <= kk - 1'b1;
          end
        end
        U_ABS: begin
          if (diff[WIDTH]) begin
            x  <= y;
            y  <= x;
            lt <= 1'b1;
          end else begin
            x    <= diff[WIDTH-1:0];
            done <= 1'b1;
            st   <= U_IDLE;
          end
        end
        default: st <= U_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/exact_symbolic_rational_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// exact_symbolic_rational_alu: exact arithmetic on (n/d)*sqrt(r)*pi^p values
// Adds, subtracts, multiplies or divides two symbolic values and returns the
// canonical reduced form, driven by a small sequencer around one shared unit.
// ----------------------------------------------------------------------------
// The coefficient work is a chain of operations in the shared unit, among
// them multiplies and divides. Square factors are pulled out of the
// radicand by trial division, with a short divide in the shared unit for
// each trial divisor and up to 2^RAD_WIDTH divisors.
// Throughput: one command at a time; busy stays high until the result beat.
// The result beat cannot be stalled. Reset (rst, synchronous) returns the
// sequencer to idle and drops any command in flight.
module exact_symbolic_rational_alu #(
  parameter int COEF_WIDTH = 32,
  parameter int RAD_WIDTH  = 16
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  output logic                          busy,
  input  wire        [1:0]              action,
  input  wire signed [COEF_WIDTH-1:0]   a_num,
  input  wire        [COEF_WIDTH-2:0]   a_den,
  input  wire        [RAD_WIDTH-1:0]    a_rad,
  input  wire                           a_pi,
  input  wire signed [COEF_WIDTH-1:0]   b_num,
  input  wire        [COEF_WIDTH-2:0]   b_den,
  input  wire        [RAD_WIDTH-1:0]    b_rad,
  input  wire                           b_pi,
  output logic                          done,
  output logic signed [COEF_WIDTH-1:0]  r_num,
  output logic       [COEF_WIDTH-2:0]   r_den,
  output logic       [2*RAD_WIDTH-1:0]  r_rad,
  output logic                          r_pi,
  output logic       [1:0]              status
);

  localparam int CW = COEF_WIDTH;
  localparam int RW = RAD_WIDTH;
  // Widest intermediate: two coefficients times a radicand-sized factor.
  localparam int W  = 2 * CW + RW;
  localparam int RR = 2 * RW;
  localparam int SW = RR + 1;
  localparam int IW = RW + 1;
  // Largest legal denominator, also the largest positive numerator.
  localparam logic [W-1:0] DMAX = {{(W - CW + 1){1'b0}}, {(CW - 1){1'b1}}};

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_PROD1, S_PROD2, S_COMB, S_PROD3, S_RADMUL, S_RADDIV,
    S_DRAD, S_SQINIT, S_SQTEST, S_SQDIV, S_FACMUL, S_NFAC, S_GCD, S_NDIV,
    S_DDIV, S_FINAL
  } state_t;

  state_t          state;
  logic            lnch;

  // Latched operands, as magnitudes with separate sign flags.
  logic [1:0]      act;
  logic            an;
  logic            bn;
  logic [CW-1:0]   am;
  logic [CW-1:0]   bm;
  logic [CW-2:0]   ad;
  logic [CW-2:0]   bd;
  logic [RW-1:0]   ra;
  logic [RW-1:0]   rb;
  logic            ap;
  logic            bp;

  // Working registers.
  logic [W-1:0]    nreg;
  logic [W-1:0]    dreg;
  logic [W-1:0]    greg;
  logic [RR-1:0]   rad;
  logic [RR-1:0]   rem;
  logic [RW-1:0]   fac;
  logic [IW-1:0]   ii;
  logic [SW-1:0]   sq;
  logic            neg;
  logic            pi_r;
  logic [1:0]      stat_r;

  logic [CW-1:0]   a_mag;
  logic [CW-1:0]   b_mag;
  logic [W-1:0]    lim;

  // Shared unit request.
  logic                 u_go;
  esr_pkg::unit_op_t    u_op;
  logic [W-1:0]         u_a;
  logic [W-1:0]         u_b;
  esr_pkg::unit_ctrl_t  u_ctrl;
  esr_pkg::unit_stat_t  u_stat;
  logic [W-1:0]         u_res;
  logic [W-1:0]         u_rmd;

  assign busy  = (state != S_IDLE);
  assign a_mag = a_num[CW-1] ? (~a_num + 1'b1) : a_num;
  assign b_mag = b_num[CW-1] ? (~b_num + 1'b1) : b_num;
  // A negative result may reach one step further than a positive one.
  assign lim   = DMAX + W'(neg);

  assign u_ctrl.start = u_go && !lnch;
  assign u_ctrl.op    = u_op;

  esr_unit #(
    .WIDTH (W),
    .SHORT (RR)
  ) u_unit (
    .clk  (clk),
    .rst  (rst),
    .ctrl (u_ctrl),
    .a    (u_a),
    .b    (u_b),
    .stat (u_stat),
    .res  (u_res),
    .rmd  (u_rmd)
  );

  // Operand selection for the shared unit in each working state.
  always_comb begin
    u_go = 1'b0;
    u_op = esr_pkg::UOP_MUL;
    u_a  = '0;
    u_b  = '0;
    case (state)
      S_PROD1: begin
        u_go = 1'b1;
        u_a  = W'(am);
        u_b  = (act == esr_pkg::ACT_MUL) ? W'(bm) : W'(bd);
      end
      S_PROD2: begin
        u_go = 1'b1;
        u_a  = W'(ad);
        u_b  = (act == esr_pkg::ACT_MUL) ? W'(bd) : W'(bm);
      end
      S_COMB: begin
        u_go = 1'b1;
        u_op = (an == bn) ? esr_pkg::UOP_ADD : esr_pkg::UOP_ABS;
        u_a  = nreg;
        u_b  = dreg;
      end
      S_PROD3: begin
        u_go = 1'b1;
        u_a  = W'(ad);
        u_b  = W'(bd);
      end
      S_RADMUL: begin
        u_go = 1'b1;
        u_a  = W'(ra);
        u_b  = W'(rb);
      end
      S_RADDIV: begin
        u_go = 1'b1;
        u_op = esr_pkg::UOP_DIVS;
        u_a  = W'(ra);
        u_b  = W'(rb);
      end
      S_DRAD: begin
        u_go = 1'b1;
        u_a  = dreg;
        u_b  = W'(rb);
      end
      S_SQDIV: begin
        u_go = 1'b1;
        u_op = esr_pkg::UOP_DIVS;
        u_a  = W'(rem);
        u_b  = W'(sq);
      end
      S_FACMUL: begin
        u_go = 1'b1;
        u_a  = W'(fac);
        u_b  = W'(ii);
      end
      S_NFAC: begin
        u_go = 1'b1;
        u_a  = nreg;
        u_b  = W'(fac);
      end
      S_GCD: begin
        u_go = 1'b1;
        u_op = esr_pkg::UOP_GCD;
        u_a  = nreg;
        u_b  = dreg;
      end
      S_NDIV: begin
        u_go = 1'b1;
        u_op = esr_pkg::UOP_DIV;
        u_a  = nreg;
        u_b  = greg;
      end
      S_DDIV: begin
        u_go = 1'b1;
        u_op = esr_pkg::UOP_DIV;
        u_a  = dreg;
        u_b  = greg;
      end
      default: u_go = 1'b0;
    endcase
  end

  // Sequencer. Each state that uses the shared unit launches one operation
  // and moves on when the unit reports done.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lnch  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (u_go && !lnch) begin
        lnch <= 1'b1;
      end else if (u_stat.done) begin
        lnch <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            act    <= action;
            an     <= a_num[CW-1];
            bn     <= b_num[CW-1];
            am     <= a_mag;
            bm     <= b_mag;
            ad     <= a_den;
            bd     <= b_den;
            ra     <= a_rad;
            rb     <= b_rad;
            ap     <= a_pi;
            bp     <= b_pi;
            stat_r <= esr_pkg::ST_OK;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          neg <= an ^ bn;
          case (act)
            esr_pkg::ACT_MUL: pi_r <= ap | bp;
            esr_pkg::ACT_DIV: pi_r <= ap & ~bp;
            default:          pi_r <= ap;
          endcase
          // Subtraction is addition of the negated right operand.
          if (act == esr_pkg::ACT_SUB) begin
            bn <= ~bn;
          end
          if (ad == '0 || bd == '0) begin
            stat_r <= esr_pkg::ST_DIVZ;
            state  <= S_FINAL;
          end else begin
            case (act)
              esr_pkg::ACT_ADD, esr_pkg::ACT_SUB: begin
                if (ra != rb || ap != bp) begin
                  stat_r <= esr_pkg::ST_FORM;
                  state  <= S_FINAL;
                end else begin
                  state <= S_PROD1;
                end
              end
              esr_pkg::ACT_MUL: begin
                if (ap && bp) begin
                  stat_r <= esr_pkg::ST_FORM;
                  state  <= S_FINAL;
                end else begin
                  state <= S_PROD1;
                end
              end
              default: begin
                if (bm == '0) begin
                  stat_r <= esr_pkg::ST_DIVZ;
                  state  <= S_FINAL;
                end else begin
                  state <= S_PROD1;
                end
              end
            endcase
          end
        end
        S_PROD1: begin
          if (u_stat.done) begin
            nreg  <= u_res;
            state <= S_PROD2;
          end
        end
        S_PROD2: begin
          if (u_stat.done) begin
            dreg <= u_res;
            case (act)
              esr_pkg::ACT_ADD, esr_pkg::ACT_SUB: state <= S_COMB;
              esr_pkg::ACT_MUL: begin
                if (ra != '0 && rb != '0) begin
                  state <= S_RADMUL;
                end else begin
                  rad   <= (ra != '0) ? RR'(ra) : RR'(rb);
                  state <= S_SQINIT;
                end
              end
              default: begin
                if (ra != '0 && rb != '0) begin
                  if (ra == rb) begin
                    rad   <= '0;
                    state <= S_SQINIT;
                  end else begin
                    state <= S_RADDIV;
                  end
                end else if (ra != '0) begin
                  rad   <= RR'(ra);
                  state <= S_SQINIT;
                end else if (rb != '0) begin
                  // Rationalize: the radical moves up, its square goes down.
                  rad   <= RR'(rb);
                  state <= S_DRAD;
                end else begin
                  rad   <= '0;
                  state <= S_SQINIT;
                end
              end
            endcase
          end
        end
        S_COMB: begin
          if (u_stat.done) begin
            nreg <= u_res;
            // On unlike signs the larger cross product decides the sign.
            if (an != bn && u_stat.lt) begin
              neg <= bn;
            end else begin
              neg <= an;
            end
            state <= S_PROD3;
          end
        end
        S_PROD3: begin
          if (u_stat.done) begin
            dreg  <= u_res;
            rad   <= RR'(ra);
            state <= S_SQINIT;
          end
        end
        S_RADMUL: begin
          if (u_stat.done) begin
            rad   <= u_res[RR-1:0];
            state <= S_SQINIT;
          end
        end
        S_RADDIV: begin
          if (u_stat.done) begin
            rad   <= (u_rmd == '0) ? u_res[RR-1:0] : '0;
            state <= S_SQINIT;
          end
        end
        S_DRAD: begin
          if (u_stat.done) begin
            dreg  <= u_res;
            state <= S_SQINIT;
          end
        end
        S_SQINIT: begin
          rem   <= rad;
          fac   <= RW'(1);
          ii    <= IW'(2);
          sq    <= SW'(4);
          state <= S_SQTEST;
        end
        S_SQTEST: begin
          if (sq > SW'(rem)) begin
            state <= S_NFAC;
          end else begin
            state <= S_SQDIV;
          end
        end
        S_SQDIV: begin
          if (u_stat.done) begin
            if (u_rmd == '0) begin
              rem   <= u_res[RR-1:0];
              state <= S_FACMUL;
            end else begin
              // (i+1)^2 = i^2 + 2i + 1
              ii    <= ii + 1'b1;
              sq    <= sq + SW'({ii, 1'b1});
              state <= S_SQTEST;
            end
          end
        end
        S_FACMUL: begin
          if (u_stat.done) begin
            fac   <= u_res[RW-1:0];
            state <= S_SQTEST;
          end
        end
        S_NFAC: begin
          if (u_stat.done) begin
            nreg  <= u_res;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          if (u_stat.done) begin
            greg  <= u_res;
            state <= S_NDIV;
          end
        end
        S_NDIV: begin
          if (u_stat.done) begin
            nreg  <= u_res;
            state <= S_DDIV;
          end
        end
        S_DDIV: begin
          if (u_stat.done) begin
            dreg  <= u_res;
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          done   <= 1'b1;
          state  <= S_IDLE;
          r_num  <= '0;
          r_den  <= (CW - 1)'(1);
          r_rad  <= '0;
          r_pi   <= 1'b0;
          status <= stat_r;
          if (stat_r == esr_pkg::ST_OK && nreg != '0) begin
            if (nreg > lim || dreg > DMAX) begin
              status <= esr_pkg::ST_OVF;
            end else begin
              r_num <= neg ? (~nreg[CW-1:0] + 1'b1) : nreg[CW-1:0];
              r_den <= dreg[CW-2:0];
              r_rad <= (rem == RR'(1)) ? '0 : rem;
              r_pi  <= pi_r;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The result beat is only raised as the sequencer returns to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  // An accepted command always occupies the sequencer in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not start work");

  // Any error status carries the canonical zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != esr_pkg::ST_OK) |->
      (r_num == '0 && r_den == (CW - 1)'(1) && r_rad == '0 && !r_pi))
    else $error("error result is not canonical zero");

  // A delivered denominator is never zero.
  a_den_nz: assert property (@(posedge clk) disable iff (rst)
    done |-> r_den != '0)
    else $error("zero denominator delivered");

endmodule
`default_nettype wire

// ===== sim/tb_exact_symbolic_rational_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_exact_symbolic_rational_alu: self-checking bench of the symbolic ALU
// Directed commands cover the corner cases of every action. Random commands
// follow in phases, two back to back and two with gaps. A scoreboard predicts
// every result beat and compares it, field by field, with the block's output.
// ----------------------------------------------------------------------------
module tb_exact_symbolic_rational_alu;

  localparam int  COEF_W = 32;
  localparam int  RAD_W  = 16;
  // Radicands are kept small enough here for trial division to end soon,
  // and the limit bounds the cycles of the whole run, with room to spare
  // for every command that the bench sends.
  localparam longint CYCLE_LIMIT = 8000000;

  typedef struct {
    logic [1:0]        act;
    logic [COEF_W-1:0] an;
    logic [COEF_W-2:0] ad;
    logic [RAD_W-1:0]  ar;
    logic              ap;
    logic [COEF_W-1:0] bn;
    logic [COEF_W-2:0] bd;
    logic [RAD_W-1:0]  br;
    logic              bp;
  } cmd_t;

  typedef struct {
    logic [COEF_W-1:0]  num;
    logic [COEF_W-2:0]  den;
    logic [2*RAD_W-1:0] rad;
    logic               pi;
    logic [1:0]         st;
  } res_t;

  typedef struct {
    longint unsigned n;
    longint unsigned d;
    bit              neg;
    bit              big;
  } frac_t;

  // Scoreboard: predicts the result of each accepted command and checks the
  // result beats in order against those predictions.
  class alu_scoreboard;
    res_t pending_q[$];
    int   errors;
    int   act_cnt[4];
    int   st_cnt[4];

    localparam longint unsigned DLIM = 64'h7FFF_FFFF;

    function automatic longint unsigned gcd(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      return x;
    endfunction

    function automatic bit mul_wraps(longint unsigned x, longint unsigned y,
                                     output longint unsigned r);
      r = 0;
      if (x != 0 && y > (64'hFFFF_FFFF_FFFF_FFFF / x)) return 1'b1;
      r = x * y;
      return 1'b0;
    endfunction

    // Multiplies the reduced fraction f by n2/d2 and keeps it reduced.
    function automatic void mul_frac(inout frac_t f, input longint unsigned n2,
                                     input longint unsigned d2);
      longint unsigned g, g1, g2, nn, dd;
      if (f.big) return;
      g  = gcd(n2, d2);
      n2 = n2 / g;
      d2 = d2 / g;
      g1 = gcd(f.n, d2);
      g2 = gcd(n2, f.d);
      if (g1 == 0) g1 = 1;
      if (g2 == 0) g2 = 1;
      if (mul_wraps(f.n / g1, n2 / g2, nn) || mul_wraps(f.d / g2, d2 / g1, dd)) begin
        f.big = 1'b1;
        return;
      end
      f.n = nn;
      f.d = dd;
    endfunction

    function automatic res_t make_res(longint unsigned n, longint unsigned d,
                                      longint unsigned rad, bit pi, logic [1:0] st);
      res_t r;
      r.num = n[COEF_W-1:0];
      r.den = d[COEF_W-2:0];
      r.rad = rad[2*RAD_W-1:0];
      r.pi  = pi;
      r.st  = st;
      return r;
    endfunction

    function automatic res_t evaluate(cmd_t c);
      longint unsigned am, bm, ad, bd, ra, rb, rad, t1, t2, mag, den, g, lim;
      longint unsigned rem, fac, i;
      bit an, bn, ap, bp, pi, sneg;
      frac_t f;
      an  = c.an[COEF_W-1];
      am  = an ? (64'd4294967296 - c.an) : c.an;
      bn  = c.bn[COEF_W-1];
      bm  = bn ? (64'd4294967296 - c.bn) : c.bn;
      ad  = c.ad;
      bd  = c.bd;
      ra  = c.ar;
      rb  = c.br;
      ap  = c.ap;
      bp  = c.bp;
      rad = 0;
      pi  = 1'b0;
      f.n = 1; f.d = 1; f.neg = 1'b0; f.big = 1'b0;

      if (ad == 0 || bd == 0) return make_res(0, 1, 0, 0, esr_pkg::ST_DIVZ);

      if (c.act == esr_pkg::ACT_ADD || c.act == esr_pkg::ACT_SUB) begin
        t1 = am * bd;
        t2 = bm * ad;
        if (c.act == esr_pkg::ACT_SUB) bn = !bn;
        if (ra != rb || ap != bp) return make_res(0, 1, 0, 0, esr_pkg::ST_FORM);
        if (an == bn) begin
          mag = t1 + t2; sneg = an;
        end else if (t1 >= t2) begin
          mag = t1 - t2; sneg = an;
        end else begin
          mag = t2 - t1; sneg = bn;
        end
        den   = ad * bd;
        g     = gcd(mag, den);
        f.n   = mag / g;
        f.d   = den / g;
        f.neg = sneg;
        rad   = ra;
        pi    = ap;
      end else if (c.act == esr_pkg::ACT_MUL) begin
        if (ap && bp) return make_res(0, 1, 0, 0, esr_pkg::ST_FORM);
        mul_frac(f, am, ad);
        mul_frac(f, bm, bd);
        f.neg = (an != bn);
        if (ra > 0 && rb > 0) rad = ra * rb;
        else if (ra > 0) rad = ra;
        else rad = rb;
        pi = ap | bp;
      end else begin
        if (bm == 0) return make_res(0, 1, 0, 0, esr_pkg::ST_DIVZ);
        mul_frac(f, am, ad);
        mul_frac(f, bd, bm);
        f.neg = (an != bn);
        if (ra > 0 && rb > 0) begin
          if (ra == rb) rad = 0;
          else if (ra % rb == 0) rad = ra / rb;
          else rad = 0;
        end else if (ra > 0) begin
          rad = ra;
        end else if (rb > 0) begin
          // A radical only in the divisor is rationalized into the denominator.
          rad = rb;
          mul_frac(f, 1, rb);
        end
        pi = ap && !bp;
      end

      if (rad == 1) begin
        rad = 0;
      end else if (rad > 1) begin
        rem = rad; fac = 1; i = 2;
        while (i * i <= rem) begin
          if (rem % (i * i) == 0) begin
            rem = rem / (i * i);
            fac = fac * i;
          end else begin
            i++;
          end
        end
        if (fac > 1) mul_frac(f, fac, 1);
        rad = (rem == 1) ? 0 : rem;
      end

      if (!f.big && f.n == 0) return make_res(0, 1, 0, 0, esr_pkg::ST_OK);
      lim = f.neg ? (DLIM + 1) : DLIM;
      if (f.big || f.n > lim || f.d > DLIM || f.d == 0)
        return make_res(0, 1, 0, 0, esr_pkg::ST_OVF);
      return make_res(f.neg ? (64'd0 - f.n) : f.n, f.d, rad, pi, esr_pkg::ST_OK);
    endfunction

    function void note_command(cmd_t c);
      act_cnt[c.act]++;
      pending_q.push_back(evaluate(c));
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: result beat with no command outstanding: num %0d den %0d rad %0d",
                 $time, $signed(got.num), got.den, got.rad);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      st_cnt[exp_r.st]++;
      if (got.num !== exp_r.num) begin
        $display("%0t: r_num expected %0d got %0d", $time, $signed(exp_r.num), $signed(got.num));
        errors++;
      end
      if (got.den !== exp_r.den) begin
        $display("%0t: r_den expected %0d got %0d", $time, exp_r.den, got.den);
        errors++;
      end
      if (got.rad !== exp_r.rad) begin
        $display("%0t: r_rad expected %0d got %0d", $time, exp_r.rad, got.rad);
        errors++;
      end
      if (got.pi !== exp_r.pi) begin
        $display("%0t: r_pi expected %0b got %0b", $time, exp_r.pi, got.pi);
        errors++;
      end
      if (got.st !== exp_r.st) begin
        $display("%0t: status expected %0d got %0d", $time, exp_r.st, got.st);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [1:0]               action = esr_pkg::ACT_ADD;
  logic signed [COEF_W-1:0] a_num = '0;
  logic [COEF_W-2:0]        a_den = '0;
  logic [RAD_W-1:0]         a_rad = '0;
  logic                     a_pi = 1'b0;
  logic signed [COEF_W-1:0] b_num = '0;
  logic [COEF_W-2:0]        b_den = '0;
  logic [RAD_W-1:0]         b_rad = '0;
  logic                     b_pi = 1'b0;
  logic                     busy;
  logic                     done;
  logic signed [COEF_W-1:0] r_num;
  logic [COEF_W-2:0]        r_den;
  logic [2*RAD_W-1:0]       r_rad;
  logic                     r_pi;
  logic [1:0]               status;

  alu_scoreboard sb = new();
  longint cycles = 0;
  int     sent = 0;

  exact_symbolic_rational_alu #(
    .COEF_WIDTH(COEF_W),
    .RAD_WIDTH (RAD_W)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .action(action),
    .a_num (a_num),
    .a_den (a_den),
    .a_rad (a_rad),
    .a_pi  (a_pi),
    .b_num (b_num),
    .b_den (b_den),
    .b_rad (b_rad),
    .b_pi  (b_pi),
    .done  (done),
    .r_num (r_num),
    .r_den (r_den),
    .r_rad (r_rad),
    .r_pi  (r_pi),
    .status(status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The result beat lasts one cycle and cannot be held off, so it is taken
  // at every edge where done was high. Values read here are the ones from
  // before the edge, since the block updates its outputs with nonblocking
  // assignments. The same process watches the cycle budget.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (!rst && done) begin
      res_t got;
      got.num = r_num;
      got.den = r_den;
      got.rad = r_rad;
      got.pi  = r_pi;
      got.st  = status;
      sb.check_result(got);
    end
  end

  // Presents one command and holds it until an edge where busy is low. The
  // caller leaves start high when the next command follows back to back.
  task automatic issue(cmd_t c);
    action <= c.act;
    a_num  <= c.an;
    a_den  <= c.ad;
    a_rad  <= c.ar;
    a_pi   <= c.ap;
    b_num  <= c.bn;
    b_den  <= c.bd;
    b_rad  <= c.br;
    b_pi   <= c.bp;
    start  <= 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_command(c);
    sent++;
  endtask

  // Random idle cycles on the sender side; pct is the chance per cycle.
  task automatic sender_gap(int pct);
    int n;
    n = 0;
    while ($urandom_range(99) < pct && n < 60) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Holds the next command back until every outstanding result has arrived.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic directed(logic [1:0] act, logic [31:0] an, logic [30:0] ad,
                          logic [15:0] ar, logic ap, logic [31:0] bn,
                          logic [30:0] bd, logic [15:0] br, logic bp);
    cmd_t c;
    c.act = act; c.an = an; c.ad = ad; c.ar = ar; c.ap = ap;
    c.bn = bn; c.bd = bd; c.br = br; c.bp = bp;
    issue(c);
  endtask

  function automatic logic [31:0] rnd_num();
    int sel;
    logic [31:0] v;
    sel = $urandom_range(99);
    if (sel < 55) v = $urandom_range(200) - 100;
    else if (sel < 80) v = $urandom_range(131070) - 65535;
    else v = $urandom;
    return v;
  endfunction

  function automatic logic [30:0] rnd_den();
    int sel;
    logic [30:0] v;
    sel = $urandom_range(99);
    if (sel < 2) return '0;
    if (sel < 60) v = 31'($urandom_range(60) + 1);
    else if (sel < 82) v = 31'($urandom_range(65535) + 1);
    else v = 31'($urandom);
    if (v == 0) v = 1;
    return v;
  endfunction

  function automatic logic [15:0] rnd_rad(bit narrow);
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return '0;
    if (sel < 85 || narrow) return 16'($urandom_range(narrow ? 255 : 63));
    return 16'($urandom_range(65535));
  endfunction

  // Most operands are reduced fractions; a few are left unreduced on purpose.
  function automatic void reduce(inout logic [31:0] n, inout logic [30:0] d);
    longint unsigned m, g;
    bit neg;
    if (d == 0 || $urandom_range(9) == 0) return;
    neg = n[31];
    m = neg ? (64'd4294967296 - n) : n;
    g = sb.gcd(m, d);
    if (g <= 1) return;
    m = m / g;
    d = 31'(d / g);
    n = 32'(neg ? (64'd4294967296 - m) : m);
  endfunction

  task automatic random_cmd(int gap_pct);
    cmd_t c;
    bit narrow;
    c.act  = 2'($urandom_range(3));
    // Trial division over a product of two wide radicands would need up to
    // 2^16 trial divisors, so multiplies use narrow radicands.
    narrow = (c.act == esr_pkg::ACT_MUL);
    c.an = rnd_num(); c.ad = rnd_den();
    c.bn = rnd_num(); c.bd = rnd_den();
    reduce(c.an, c.ad);
    reduce(c.bn, c.bd);
    c.ar = rnd_rad(narrow);
    c.br = rnd_rad(narrow);
    c.ap = ($urandom_range(3) == 0);
    c.bp = ($urandom_range(3) == 0);
    // Sums only stay exact for like terms, so most of them get matching forms.
    if ((c.act == esr_pkg::ACT_ADD || c.act == esr_pkg::ACT_SUB) &&
        $urandom_range(9) < 7) begin
      c.br = c.ar;
      c.bp = c.ap;
      if ($urandom_range(4) == 0) begin
        c.bn = c.an; c.bd = c.ad;
      end
    end
    if (c.act == esr_pkg::ACT_DIV && $urandom_range(3) == 0) begin
      case ($urandom_range(2))
        0: c.br = c.ar;
        1: begin
          c.br = 16'($urandom_range(15) + 2);
          c.ar = 16'(c.br * ($urandom_range(60) + 1));
        end
        default: c.bn = '0;
      endcase
    end
    issue(c);
    sender_gap(gap_pct);
  endtask

  initial begin
    int phase_pct[4];
    phase_pct = '{0, 79, 0, 21};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: like and unlike terms, cancellation, the radical and pi
    // rules of multiply and divide, zero divisors and denominators,
    // unreduced operands, square radicands and the coefficient extremes.
    directed(esr_pkg::ACT_ADD, 3, 4, 2, 0, 5, 6, 2, 0);
    directed(esr_pkg::ACT_SUB, 7, 3, 5, 1, 7, 3, 5, 1);
    directed(esr_pkg::ACT_ADD, 1, 2, 2, 0, 1, 2, 3, 0);
    directed(esr_pkg::ACT_SUB, 1, 2, 0, 1, 1, 2, 0, 0);
    directed(esr_pkg::ACT_MUL, 2, 3, 0, 1, 3, 5, 0, 1);
    directed(esr_pkg::ACT_MUL, 1, 1, 2, 0, 1, 1, 2, 0);
    directed(esr_pkg::ACT_MUL, -3, 7, 6, 1, 5, 2, 10, 0);
    directed(esr_pkg::ACT_DIV, 4, 9, 7, 0, -2, 3, 7, 0);
    directed(esr_pkg::ACT_DIV, 1, 1, 6, 0, 1, 1, 3, 0);
    directed(esr_pkg::ACT_DIV, 1, 1, 5, 0, 1, 1, 3, 0);
    directed(esr_pkg::ACT_DIV, 1, 1, 0, 0, 1, 1, 3, 0);
    directed(esr_pkg::ACT_DIV, 1, 1, 0, 0, 1, 1, 0, 1);
    directed(esr_pkg::ACT_DIV, 2, 1, 0, 1, 3, 1, 0, 0);
    directed(esr_pkg::ACT_DIV, 5, 1, 0, 0, 0, 1, 0, 0);
    directed(esr_pkg::ACT_ADD, 1, 0, 0, 0, 1, 1, 0, 0);
    directed(esr_pkg::ACT_MUL, 1, 1, 0, 0, 1, 0, 0, 0);
    directed(esr_pkg::ACT_ADD, 32'h8000_0000, 1, 0, 0, 0, 1, 0, 0);
    directed(esr_pkg::ACT_SUB, 32'h8000_0000, 1, 0, 0, 1, 1, 0, 0);
    directed(esr_pkg::ACT_MUL, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 65535, 0,
             32'h7FFF_FFFF, 1, 0, 0);
    directed(esr_pkg::ACT_MUL, 32'h7FFF_FFFF, 1, 0, 0, 32'h7FFF_FFFF, 1, 0, 0);
    directed(esr_pkg::ACT_MUL, 2, 4, 1, 0, 6, 9, 4, 0);
    directed(esr_pkg::ACT_ADD, 5, 1, 16'hFFFF, 1, -5, 1, 16'hFFFF, 1);
    directed(esr_pkg::ACT_DIV, 1, 31'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 1, 8, 0);
    directed(esr_pkg::ACT_ADD, 0, 1, 12, 0, 0, 1, 12, 0);

    // The sender waits here for every result before the random part.
    drain();

    for (int p = 0; p < 4; p++) begin
      repeat (25) random_cmd(phase_pct[p]);
      if (p == 1) drain();
    end
    start <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Ran %0d commands: %0d add, %0d subtract, %0d multiply, %0d divide.",
             sent, sb.act_cnt[0], sb.act_cnt[1], sb.act_cnt[2], sb.act_cnt[3]);
    $display("Results by status: %0d exact, %0d form, %0d divide by zero, %0d overflow.",
             sb.st_cnt[0], sb.st_cnt[1], sb.st_cnt[2], sb.st_cnt[3]);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
